FILE: rtl/ppxdc_pkg.sv
// Shared constants, the response payload type and the text ROM for the packet decrypt-check block.
package ppxdc_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned FIELD_LENGTH_WIDTH = 16;

   localparam logic [31:0] KEY_MULT = 32'h6765_7268;
   localparam logic [7:0]  BYTE_INV = 8'hFF;
   localparam logic [7:0]  X2_LIMIT = 8'd220;
   localparam logic [7:0]  M1_MIN   = 8'd10;
   localparam int unsigned MIN_CHECK_LENGTH = 7;
   localparam int unsigned PLAIN_POS_FOUR   = 4;
   localparam int unsigned PLAIN_POS_SIX    = 6;
   localparam int unsigned CHECK_LAST_POS   = 3;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] byte_out;
      logic                  last_byte;
      logic                  packet_ok;
   } rsp_payload_type;

   // Text table used both as key salt and as the reference for the check byte
   localparam logic [7:0] TEXT_ROM [0:255] = '{
      8'h41,8'h73,8'h20,8'h70,8'h61,8'h72,8'h74,8'h20,
      8'h6F,8'h66,8'h20,8'h74,8'h68,8'h69,8'h73,8'h20,
      8'h73,8'h6F,8'h66,8'h74,8'h77,8'h61,8'h72,8'h65,
      8'h20,8'h62,8'h65,8'h74,8'h61,8'h20,8'h76,8'h65,
      8'h72,8'h73,8'h69,8'h6F,8'h6E,8'h20,8'h4D,8'h69,
      8'h72,8'h61,8'h62,8'h69,8'h6C,8'h69,8'h73,8'h20,
      8'h69,8'h73,8'h20,
      8'h67,8'h72,8'h61,8'h6E,8'h74,8'h69,8'h6E,8'h67,
      8'h20,8'h61,8'h20,8'h6C,8'h69,8'h6D,8'h69,8'h74,
      8'h65,8'h64,8'h20,8'h61,8'h63,8'h63,8'h65,8'h73,
      8'h73,8'h20,8'h74,8'h6F,8'h20,8'h74,8'h68,8'h65,
      8'h20,8'h49,8'h43,8'h51,8'h20,8'h6E,8'h65,8'h74,
      8'h77,8'h6F,8'h72,8'h6B,8'h2C,8'h20,
      8'h73,8'h65,8'h72,8'h76,8'h65,8'h72,8'h73,8'h2C,
      8'h20,8'h64,8'h69,8'h72,8'h65,8'h63,8'h74,8'h6F,
      8'h72,8'h69,8'h65,8'h73,8'h2C,8'h20,8'h6C,8'h69,
      8'h73,8'h74,8'h69,8'h6E,8'h67,8'h73,8'h2C,8'h20,
      8'h69,8'h6E,8'h66,8'h6F,8'h72,8'h6D,8'h61,8'h74,
      8'h69,8'h6F,8'h6E,8'h20,8'h61,8'h6E,8'h64,8'h20,
      8'h64,8'h61,8'h74,8'h61,8'h62,8'h61,8'h73,8'h65,
      8'h73,8'h20,8'h28,8'h22,
      8'h49,8'h43,8'h51,8'h20,8'h53,8'h65,8'h72,8'h76,
      8'h69,8'h63,8'h65,8'h73,8'h20,8'h61,8'h6E,8'h64,
      8'h20,8'h49,8'h6E,8'h66,8'h6F,8'h72,8'h6D,8'h61,
      8'h74,8'h69,8'h6F,8'h6E,8'h22,8'h29,8'h2E,8'h20,
      8'h54,8'h68,8'h65,8'h20,
      8'h49,8'h43,8'h51,8'h20,8'h53,8'h65,8'h72,8'h76,
      8'h69,8'h63,8'h65,8'h20,8'h61,8'h6E,8'h64,8'h20,
      8'h49,8'h6E,8'h66,8'h6F,8'h72,8'h6D,8'h61,8'h74,
      8'h69,8'h6F,8'h6E,8'h20,8'h6D,8'h61,8'h79,8'h20,
      8'h64,8'h61,8'h74,8'h61,8'h62,8'h61,8'h73,8'h65,
      8'h73,8'h20,8'h28,8'h22,
      8'h49,8'h43,8'h51,8'h20,8'h53,8'h65,8'h72,8'h76,
      8'h69,8'h63,8'h65,8'h73,8'h20,8'h61,8'h6E,8'h64,
      8'h20,8'h49,8'h6E
   };

endpackage

FILE: rtl/ppxdc_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface ppxdc_req_if
   import ppxdc_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic [BYTE_WIDTH-1:0]         byte_in;
   logic [FIELD_LENGTH_WIDTH-1:0] packet_length;

   modport source (output valid, output byte_in, output packet_length, input ready);
   modport sink   (input valid, input byte_in, input packet_length, output ready);
endinterface

interface ppxdc_rsp_if
   import ppxdc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] byte_out;
   logic                  last_byte;
   logic                  packet_ok;

   modport source (output valid, output byte_out, output last_byte, output packet_ok,
                   input ready);
   modport sink   (input valid, input byte_out, input last_byte, input packet_ok,
                   output ready);
endinterface

FILE: rtl/peer_packet_xor_decrypt_check_top.sv
// Streaming packet decrypt-and-check block: one request byte in, one decrypted byte out.
//
// Packets enter one byte per request, from offset zero; the length field is sampled on the
// first byte only and masked to LENGTH_BITS. Bytes 0..3 pass unchanged and form the
// little-endian check word; the key is 0x67657268 * length + check. Each aligned word below
// (length+3)/4 is XORed with key + ROM[word offset], lowest byte first. Every request gives
// exactly one response, carrying the decrypted byte, a last-byte flag and,
// on the last byte, the pass/fail verdict of the marker and ROM checks (always fail below
// seven bytes). The block takes one request every clock while the skid stage is empty: each
// byte passes once through the key add, ROM lookup and compares between the request edge and
// the response register. A skid stage behind the response register takes one more request
// while the response side stalls; ready drops only when both stages hold a response.
module peer_packet_xor_decrypt_check_top
   import ppxdc_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   ppxdc_req_if.sink     req_if,
   ppxdc_rsp_if.source   rsp_if
);

   localparam int unsigned LB = LENGTH_BITS;

   // Packet state
   logic [LB-1:0]   pos_ff, pos_in;
   logic [LB-1:0]   len_ff, len_in;
   logic [31:0]     check_ff, check_in;
   logic [31:0]     key_ff, key_in;
   logic [7:0]      plain4_ff, plain4_in;
   logic [31:0]     mixed_ff, mixed_in;
   logic [7:0]      marker_ff, marker_in;
   logic            marker_seen_ff, marker_seen_in;

   // Response register and skid stage
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;

   logic            accept;
   logic            take;
   logic [LB-1:0]   len_cur;
   logic            first_byte;
   logic [LB-1:0]   word_pos;
   logic [LB:0]     len_plus3;
   logic [LB-2:0]   quarter_len;
   logic            in_crypt;
   logic [31:0]     hex_word;
   logic [7:0]      hex_byte;
   logic [7:0]      res_byte;
   logic            last;
   logic [7:0]      m1;
   logic [7:0]      x2;
   logic            rom_ok;
   logic            packet_ok;
   rsp_payload_type new_rsp;

   assign accept = req_if.valid && req_if.ready;
   assign take   = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = !skid_valid_ff;

   // Pick the length: sampled on the first byte, held afterwards
   assign first_byte = (pos_ff == '0);
   assign len_cur    = first_byte ? req_if.packet_length[LB-1:0] : len_ff;

   // Decide whether this byte lies in an encrypted word and build its key byte
   assign word_pos    = {pos_ff[LB-1:2], 2'b00};
   assign len_plus3   = {1'b0, len_cur} + (LB+1)'(3);
   assign quarter_len = len_plus3[LB:2];
   assign in_crypt    = (pos_ff[LB-1:2] != '0) && (word_pos < {1'b0, quarter_len});
   assign hex_word    = key_ff + {24'h0, TEXT_ROM[word_pos[7:0]]};

   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: hex_byte = hex_word[7:0];
         2'd1: hex_byte = hex_word[15:8];
         2'd2: hex_byte = hex_word[23:16];
         default: hex_byte = hex_word[31:24];
      endcase
   end

   assign res_byte = in_crypt ? (req_if.byte_in ^ hex_byte) : req_if.byte_in;
   assign last     = ({1'b0, pos_ff} + (LB+1)'(1)) >= {1'b0, len_cur};

   // Advance the packet state
   always_comb begin
      len_in         = len_ff;
      check_in       = check_ff;
      key_in         = key_ff;
      plain4_in      = plain4_ff;
      mixed_in       = mixed_ff;
      marker_in      = marker_ff;
      marker_seen_in = marker_seen_ff;

      if (first_byte) begin
         len_in         = len_cur;
         plain4_in      = '0;
         mixed_in       = '0;
         marker_in      = '0;
         marker_seen_in = 1'b0;
      end

      // Collect the check word; the length product is staged ahead of the key add
      unique case (pos_ff)
         LB'(0): begin
            check_in = {24'h0, req_if.byte_in};
            key_in   = 32'(KEY_MULT * {{(32-LB){1'b0}}, len_cur});
         end
         LB'(1): check_in = {check_ff[31:16], req_if.byte_in, check_ff[7:0]};
         LB'(2): check_in = {check_ff[31:24], req_if.byte_in, check_ff[15:0]};
         LB'(CHECK_LAST_POS): begin
            check_in = {req_if.byte_in, check_ff[23:0]};
            key_in   = key_ff + {req_if.byte_in, check_ff[23:0]};
         end
         default: ;
      endcase

      if (pos_ff == LB'(PLAIN_POS_FOUR)) begin
         plain4_in = res_byte;
      end
      if (pos_ff == LB'(PLAIN_POS_SIX)) begin
         mixed_in = {plain4_ff, res_byte, plain4_ff, res_byte} ^ check_ff;
      end
      if ((pos_ff > LB'(PLAIN_POS_SIX)) && (pos_ff == LB'(mixed_ff[31:24]))) begin
         marker_in      = res_byte;
         marker_seen_in = 1'b1;
      end

      pos_in = last ? '0 : LB'({1'b0, pos_ff} + (LB+1)'(1));
   end

   // Verify the packet on its last byte
   assign m1     = mixed_ff[31:24];
   assign x2     = mixed_ff[15:8];
   assign rom_ok = (x2 >= X2_LIMIT) || ((TEXT_ROM[x2] ^ BYTE_INV) == mixed_ff[7:0]);
   assign packet_ok = last && (len_cur >= LB'(MIN_CHECK_LENGTH)) && (m1 >= M1_MIN) &&
                      (LB'(m1) < len_cur) && marker_seen_in &&
                      ((marker_in ^ BYTE_INV) == mixed_ff[23:16]) && rom_ok;

   assign new_rsp = '{byte_out: res_byte, last_byte: last, packet_ok: packet_ok};

   // Steer responses through the output register and skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_rsp;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end else begin
         // Hold both stages while the response side stalls
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         len_ff         <= '0;
         check_ff       <= '0;
         key_ff         <= '0;
         plain4_ff      <= '0;
         mixed_ff       <= '0;
         marker_ff      <= '0;
         marker_seen_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff         <= pos_in;
            len_ff         <= len_in;
            check_ff       <= check_in;
            key_ff         <= key_in;
            plain4_ff      <= plain4_in;
            mixed_ff       <= mixed_in;
            marker_ff      <= marker_in;
            marker_seen_ff <= marker_seen_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Response payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.byte_out  = out_ff.byte_out;
   assign rsp_if.last_byte = out_ff.last_byte;
   assign rsp_if.packet_ok = out_ff.packet_ok;

   // The skid stage only fills behind a held response
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a request with the output register empty");

   // A stalled response plus a new request must land in the skid stage
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready && accept) |=> skid_valid_ff)
      else $error("request lost while the response side stalled");

   // A verdict is only given on the last byte
   a_ok_on_last : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.packet_ok) |-> out_ff.last_byte)
      else $error("packet verdict raised on a byte other than the last");

   // The last byte returns the position to the packet start
   a_wrap_on_last : assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (pos_ff == '0))
      else $error("byte position did not return to zero after the last byte");

endmodule

FILE: tb/ppxdc_decrypt_checker.sv
// Response checker for the packet decrypt-check block: predicts every response byte and compares.
`timescale 1ns / 100ps
module ppxdc_decrypt_checker
   import ppxdc_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ppxdc_req_if        req_mon,
   ppxdc_rsp_if        rsp_mon,
   output int unsigned fault_count,
   output int unsigned pending_count,
   output int unsigned passed_packets
);

   localparam logic [FIELD_LENGTH_WIDTH-1:0] LEN_MASK =
      FIELD_LENGTH_WIDTH'((32'd1 << LENGTH_BITS) - 1);
   localparam int unsigned REPORT_LIMIT = 10;

   // Salt text, kept apart from the package copy so a bad ROM entry shows up
   localparam logic [7:0] SALT_TEXT [0:255] = '{
      8'h41,8'h73,8'h20,8'h70,8'h61,8'h72,8'h74,8'h20,8'h6F,8'h66,8'h20,8'h74,8'h68,8'h69,8'h73,8'h20,
      8'h73,8'h6F,8'h66,8'h74,8'h77,8'h61,8'h72,8'h65,8'h20,8'h62,8'h65,8'h74,8'h61,8'h20,8'h76,8'h65,
      8'h72,8'h73,8'h69,8'h6F,8'h6E,8'h20,8'h4D,8'h69,8'h72,8'h61,8'h62,8'h69,8'h6C,8'h69,8'h73,8'h20,
      8'h69,8'h73,8'h20,
      8'h67,8'h72,8'h61,8'h6E,8'h74,8'h69,8'h6E,8'h67,8'h20,8'h61,8'h20,8'h6C,8'h69,8'h6D,8'h69,8'h74,
      8'h65,8'h64,8'h20,8'h61,8'h63,8'h63,8'h65,8'h73,8'h73,8'h20,8'h74,8'h6F,8'h20,8'h74,8'h68,8'h65,
      8'h20,8'h49,8'h43,8'h51,8'h20,8'h6E,8'h65,8'h74,8'h77,8'h6F,8'h72,8'h6B,8'h2C,8'h20,
      8'h73,8'h65,8'h72,8'h76,8'h65,8'h72,8'h73,8'h2C,8'h20,8'h64,8'h69,8'h72,8'h65,8'h63,8'h74,8'h6F,
      8'h72,8'h69,8'h65,8'h73,8'h2C,8'h20,8'h6C,8'h69,8'h73,8'h74,8'h69,8'h6E,8'h67,8'h73,8'h2C,8'h20,
      8'h69,8'h6E,8'h66,8'h6F,8'h72,8'h6D,8'h61,8'h74,8'h69,8'h6F,8'h6E,8'h20,8'h61,8'h6E,8'h64,8'h20,
      8'h64,8'h61,8'h74,8'h61,8'h62,8'h61,8'h73,8'h65,8'h73,8'h20,8'h28,8'h22,
      8'h49,8'h43,8'h51,8'h20,8'h53,8'h65,8'h72,8'h76,8'h69,8'h63,8'h65,8'h73,8'h20,8'h61,8'h6E,8'h64,
      8'h20,8'h49,8'h6E,8'h66,8'h6F,8'h72,8'h6D,8'h61,8'h74,8'h69,8'h6F,8'h6E,8'h22,8'h29,8'h2E,8'h20,
      8'h54,8'h68,8'h65,8'h20,
      8'h49,8'h43,8'h51,8'h20,8'h53,8'h65,8'h72,8'h76,8'h69,8'h63,8'h65,8'h20,8'h61,8'h6E,8'h64,8'h20,
      8'h49,8'h6E,8'h66,8'h6F,8'h72,8'h6D,8'h61,8'h74,8'h69,8'h6F,8'h6E,8'h20,8'h6D,8'h61,8'h79,8'h20,
      8'h64,8'h61,8'h74,8'h61,8'h62,8'h61,8'h73,8'h65,8'h73,8'h20,8'h28,8'h22,
      8'h49,8'h43,8'h51,8'h20,8'h53,8'h65,8'h72,8'h76,8'h69,8'h63,8'h65,8'h73,8'h20,8'h61,8'h6E,8'h64,
      8'h20,8'h49,8'h6E
   };

   // Predictor state for the packet in flight
   logic [FIELD_LENGTH_WIDTH-1:0] offset_q;
   logic [FIELD_LENGTH_WIDTH-1:0] length_q;
   logic [31:0]                   check_q;
   logic [31:0]                   key_q;
   logic [31:0]                   mix_q;
   logic [7:0]                    plain_four_q;
   logic [7:0]                    marker_q;
   logic                          marker_seen_q;

   rsp_payload_type decrypted_due [$];
   int unsigned     faults;
   int unsigned     passes;
   int unsigned     response_index;

   // Work out the response for one request byte and advance the packet state
   function automatic rsp_payload_type decrypt_byte(input logic [7:0] raw,
                                                    input logic [FIELD_LENGTH_WIDTH-1:0] len_in);
      logic [FIELD_LENGTH_WIDTH-1:0] offset;
      logic [31:0]                   word_base;
      logic [31:0]                   pad;
      logic [7:0]                    plain;
      logic [7:0]                    m1;
      logic [7:0]                    x2;
      rsp_payload_type               r;
      offset = offset_q;
      // Sample the length and start afresh on the first byte
      if (offset == '0) begin
         length_q      = len_in & LEN_MASK;
         check_q       = '0;
         key_q         = '0;
         mix_q         = '0;
         plain_four_q  = '0;
         marker_q      = '0;
         marker_seen_q = 1'b0;
      end
      plain = raw;
      if (offset <= CHECK_LAST_POS) begin
         check_q[8*offset[1:0] +: 8] = raw;
         if (offset == CHECK_LAST_POS)
            key_q = KEY_MULT * 32'(length_q) + check_q;
      end else begin
         // Only words in the first quarter of the packet are masked
         word_base = 32'(offset) & ~32'd3;
         if (word_base < (32'(length_q) + 32'd3) / 32'd4) begin
            pad   = key_q + 32'(SALT_TEXT[word_base[7:0]]);
            plain = raw ^ pad[8*offset[1:0] +: 8];
         end
      end
      if (offset == PLAIN_POS_FOUR)
         plain_four_q = plain;
      if (offset == PLAIN_POS_SIX)
         mix_q = {plain_four_q, plain, plain_four_q, plain} ^ check_q;
      if (offset > PLAIN_POS_SIX && offset == 16'(mix_q[31:24])) begin
         marker_q      = plain;
         marker_seen_q = 1'b1;
      end
      r.byte_out  = plain;
      r.packet_ok = 1'b0;
      r.last_byte = (17'(offset) + 17'd1 >= 17'(length_q));
      // Verdict on the last byte; short packets always fail
      if (r.last_byte) begin
         if (length_q >= MIN_CHECK_LENGTH) begin
            m1 = mix_q[31:24];
            x2 = mix_q[15:8];
            r.packet_ok = (m1 >= M1_MIN) && (16'(m1) < length_q) && marker_seen_q &&
                          ((marker_q ^ BYTE_INV) == mix_q[23:16]);
            if (x2 < X2_LIMIT && (SALT_TEXT[x2] ^ BYTE_INV) != mix_q[7:0])
               r.packet_ok = 1'b0;
         end
         offset_q = '0;
      end else begin
         offset_q = (offset + 1'b1) & LEN_MASK;
      end
      return r;
   endfunction

   // Count a failure and report the first few
   function automatic void log_fault(input string msg);
      faults++;
      if (faults <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      rsp_payload_type seen;
      rsp_payload_type want;
      if (reset) begin
         offset_q      = '0;
         length_q      = '0;
         check_q       = '0;
         key_q         = '0;
         mix_q         = '0;
         plain_four_q  = '0;
         marker_q      = '0;
         marker_seen_q = 1'b0;
         decrypted_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            decrypted_due.push_back(decrypt_byte(req_mon.byte_in, req_mon.packet_length));
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.byte_out  = rsp_mon.byte_out;
            seen.last_byte = rsp_mon.last_byte;
            seen.packet_ok = rsp_mon.packet_ok;
            if (decrypted_due.size() == 0) begin
               log_fault($sformatf("response %0d arrived with no request outstanding",
                                   response_index));
            end else begin
               want = decrypted_due.pop_front();
               if (seen.byte_out !== want.byte_out || seen.last_byte !== want.last_byte ||
                   seen.packet_ok !== want.packet_ok)
                  log_fault($sformatf(
                     "response %0d byte/last/ok expected %02h/%0b/%0b got %02h/%0b/%0b",
                     response_index, want.byte_out, want.last_byte, want.packet_ok,
                     seen.byte_out, seen.last_byte, seen.packet_ok));
               else if (want.last_byte && want.packet_ok)
                  passes++;
            end
            response_index++;
         end
      end
      fault_count    <= faults;
      pending_count  <= decrypted_due.size();
      passed_packets <= passes;
   end

endmodule

FILE: tb/peer_packet_xor_decrypt_check_top_tb.sv
// Stimulus and verdict for the packet decrypt-check block, with the response checker beside it.
`timescale 1ns / 100ps
module peer_packet_xor_decrypt_check_top_tb;
   import ppxdc_pkg::*;

   localparam int unsigned LENGTH_BITS   = 16;
   localparam int unsigned BYTE_TARGET   = 1250;
   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned IDLE_PERCENT  = 8;
   localparam int unsigned LARGEST_LEN   = 65535;
   localparam int unsigned LONG_PREFIX   = 40;
   localparam int unsigned SEALED_MIN    = 11;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fault_count;
   int unsigned pending_count;
   int unsigned passed_packets;
   int unsigned stall_cycles;
   int unsigned bytes_sent;
   int unsigned packets_sent;
   bit          steady;

   ppxdc_req_if req_bus ();
   ppxdc_rsp_if rsp_bus ();

   peer_packet_xor_decrypt_check_top #(
      .LENGTH_BITS (LENGTH_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   ppxdc_decrypt_checker #(
      .LENGTH_BITS (LENGTH_BITS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fault_count    (fault_count),
      .pending_count  (pending_count),
      .passed_packets (passed_packets)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Keep a stretch in the middle of the run free of idling on both sides
   assign steady = (bytes_sent >= 500 && bytes_sent < 800);

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one request byte and hold it until accepted
   task automatic push_byte(input logic [7:0] data, input logic [15:0] len);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.byte_in       <= data;
      req_bus.packet_length <= len;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Send a packet of random or alternating fixed-fill bytes; a zero length still takes one byte
   task automatic send_noise_packet(input int unsigned len, input bit fixed_fill,
                                    input logic [7:0] fill);
      int unsigned count;
      count = (len == 0) ? 1 : len;
      for (int i = 0; i < count; i++)
         push_byte(fixed_fill ? (fill ^ {8{i[0]}}) : 8'($urandom),
                   (i == 0) ? 16'(len) : 16'($urandom));
      packets_sent++;
   endtask

   // Build a packet that passes the marker and text checks, mask it, optionally spoil it
   task automatic send_sealed_packet(input int unsigned len, input bit spoil);
      logic [7:0]  body [];
      logic [7:0]  p4;
      logic [7:0]  p6;
      logic [7:0]  m1;
      logic [7:0]  x2;
      logic [7:0]  c23;
      logic [31:0] check;
      logic [31:0] key;
      logic [31:0] pad;
      int unsigned word_base;
      int unsigned idx;
      int unsigned flip;
      body = new[len];
      foreach (body[i])
         body[i] = 8'($urandom);
      p4  = 8'($urandom);
      p6  = 8'($urandom);
      x2  = 8'($urandom);
      c23 = 8'($urandom);
      m1  = 8'($urandom_range(M1_MIN, (len - 1 > 255) ? 255 : len - 1));
      check = {p4 ^ m1, c23, p4 ^ x2,
               p6 ^ ((x2 < X2_LIMIT) ? (TEXT_ROM[x2] ^ BYTE_INV) : 8'($urandom))};
      for (int i = 0; i <= CHECK_LAST_POS; i++)
         body[i] = check[8*i +: 8];
      body[PLAIN_POS_FOUR] = p4;
      body[PLAIN_POS_SIX]  = p6;
      body[m1]             = c23 ^ p6 ^ BYTE_INV;
      // Mask the first quarter with the key stream
      key = KEY_MULT * 32'(len) + check;
      for (int i = CHECK_LAST_POS + 1; i < len; i++) begin
         word_base = i & ~3;
         if (word_base < (len + 3) / 4) begin
            pad     = key + 32'(TEXT_ROM[word_base[7:0]]);
            body[i] = body[i] ^ pad[8*(i % 4) +: 8];
         end
      end
      // Flip one bit of one byte
      if (spoil) begin
         idx  = $urandom_range(0, len - 1);
         flip = $urandom_range(0, 7);
         body[idx][flip] = ~body[idx][flip];
      end
      foreach (body[i])
         push_byte(body[i], (i == 0) ? 16'(len) : 16'($urandom));
      packets_sent++;
   endtask

   // Drop valid and hold until every response has come back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned pick;
      bit          paused;
      paused                = 1'b0;
      req_bus.valid         <= 1'b0;
      req_bus.byte_in       <= '0;
      req_bus.packet_length <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero length, one byte, longest short packet, shortest checked packet
      send_noise_packet(0, 1'b1, 8'hFF);
      send_noise_packet(1, 1'b1, 8'h00);
      send_noise_packet(MIN_CHECK_LENGTH - 1, 1'b1, 8'hFF);
      send_noise_packet(MIN_CHECK_LENGTH, 1'b1, 8'h00);
      send_sealed_packet(SEALED_MIN, 1'b0);

      // Random: mostly well-formed packets, some spoiled, some noise
      while (bytes_sent < BYTE_TARGET) begin
         if (!paused && bytes_sent >= BYTE_TARGET / 2) begin
            drain_responses();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_sealed_packet(($urandom_range(0, 9) == 0) ? $urandom_range(65, 300)
                                                           : $urandom_range(SEALED_MIN, 64),
                               1'b0);
         else if (pick < 80)
            send_sealed_packet($urandom_range(SEALED_MIN, 64), 1'b1);
         else
            send_noise_packet($urandom_range(0, 40), 1'b0, 8'h00);
      end

      // Open a packet at the largest length and stop partway, so the key takes the full length
      for (int i = 0; i < LONG_PREFIX; i++)
         push_byte(8'($urandom), (i == 0) ? 16'(LARGEST_LEN) : 16'($urandom));

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d packets, %0d bytes; %0d packets passed the marker check.",
               packets_sent, bytes_sent, passed_packets);
      $display("Lengths from zero to %0d, with short, spoiled and noise packets mixed in.",
               LARGEST_LEN);
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
